>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is written by the caller, parenthesized or with a leading delay.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error("assertion failed");

`endif

>>> hw/rtl/iitc_pkg.sv
// ----------------------------------------------------------------------------
// iitc_pkg
// Types and constants for the integral image threshold count unit.
// ----------------------------------------------------------------------------
package iitc_pkg;

	localparam int CELL_W      = 16;
	localparam int SUM_W       = 36;
	localparam int HIT_W       = 21;
	localparam int ROW_WIDTH_W = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 36;

	localparam logic [HIT_W-1:0] HIT_MAX = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUM_LIMIT = 2'd1;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic              grid_end;
	} pixel_t;

	typedef struct packed {
		logic [SUM_W-1:0] area_sum;
		logic             within_limit;
		logic [HIT_W-1:0] hits_so_far;
		logic             final_cell;
	} result_t;

endpackage

>>> hw/rtl/integral_image_threshold_count_unit.sv
// Path: an accepted pixel waits in stage 1 while its line store entry is read,
// then enters the result register when that is free, and transfers from there
// unless the output stalls. The line store reads and writes once per cycle.
// Throughput: one pixel per cycle while the output does not stall.
// Reset: asynchronous, active low; clears position, row sum, count and the
// configuration (row width MAX_COLS, limit 0). The line store is not cleared.
// ----------------------------------------------------------------------------
// integral_image_threshold_count_unit
// Streaming summed-area table over a raster-order pixel stream. Each result
// carries the integral image value of its pixel, a flag for values at or below
// a programmable limit, and the running count of flagged pixels in the grid.
// ----------------------------------------------------------------------------
module integral_image_threshold_count_unit #(
	parameter int MAX_COLS = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Pixel channel.
	input  logic                                  pixel_valid,
	output logic                                  pixel_stall,
	input  iitc_pkg::pixel_t                      pixel,
	// Result channel.
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output iitc_pkg::result_t                     result,
	// Configuration write channel.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [iitc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [iitc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	import iitc_pkg::*;

	// Column index width, and a width able to hold any effective row width.
	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int EW_W  = ($clog2(MAX_COLS + 1) > ROW_WIDTH_W) ?
		$clog2(MAX_COLS + 1) : ROW_WIDTH_W;
	localparam logic [EW_W-1:0] MAX_COLS_EW = EW_W'(MAX_COLS);
	// The row width register is only 11 bits wide; saturate its reset value.
	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST =
		(MAX_COLS > (2 ** ROW_WIDTH_W) - 1) ? '1 : ROW_WIDTH_W'(MAX_COLS);

	// Configuration registers.
	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [SUM_W-1:0]       sum_limit_q;

	// Accept-side position tracking.
	logic [COL_W-1:0] col_q;
	logic             first_row_q;

	// Stage 1: the pixel waits here while its line store entry is read.
	logic             valid_s1;
	logic [CELL_W-1:0] cell_s1;
	logic             last_s1;
	logic             row_end_s1;
	logic             first_s1;
	logic [COL_W-1:0] col_s1;
	logic             byp_s1;
	logic [SUM_W-1:0] byp_data_s1;

	// Row sum and hit count, updated as each pixel leaves stage 1.
	logic [SUM_W-1:0] rsum_q;
	logic [HIT_W-1:0] hit_q;

	// Result register.
	logic    result_valid_q;
	result_t result_q;

	logic             accept;
	logic             advance;
	logic [EW_W-1:0]  width_ext;
	logic [EW_W-1:0]  eff_width;
	logic             row_end;
	logic [SUM_W-1:0] ram_rdata;
	logic [SUM_W-1:0] rsum_sum;
	logic [SUM_W-1:0] above;
	logic [SUM_W-1:0] area;
	logic             hit;
	logic [HIT_W-1:0] hit_next;

	assign cfg_ready = 1'b1;

	// Stage 1 moves into the result register whenever that register is free
	// or is being emptied by a transfer in this cycle.
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign pixel_stall  = valid_s1 && !advance;
	assign accept       = pixel_valid && !pixel_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A width of zero acts as one, and a width beyond the line store acts as
	// the line store depth.
	assign width_ext = EW_W'(row_width_q);
	always_comb begin
		if (row_width_q == '0) begin
			eff_width = EW_W'(1);
		end else if (width_ext > MAX_COLS_EW) begin
			eff_width = MAX_COLS_EW;
		end else begin
			eff_width = width_ext;
		end
	end

	assign row_end = (EW_W'(col_q) + EW_W'(1)) >= eff_width;

	// Line store: written with each pixel's area as it leaves stage 1, read
	// at the column of the pixel being accepted.
	iitc_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_COLS)
	) u_line_store (
		.clk   (clk),
		.we    (advance),
		.waddr (col_s1),
		.wdata (area),
		.re    (accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// With a one-column row the accepted pixel reads the entry that the
	// pixel ahead of it writes in the same cycle, so that value is forwarded.
	assign rsum_sum = rsum_q + SUM_W'(cell_s1);
	assign above    = first_s1 ? '0 : (byp_s1 ? byp_data_s1 : ram_rdata);
	assign area     = rsum_sum + above;
	assign hit      = area <= sum_limit_q;
	assign hit_next = (hit && (hit_q != HIT_MAX)) ? hit_q + HIT_W'(1) : hit_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
			sum_limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROW_WIDTH: row_width_q <= cfg_data[ROW_WIDTH_W-1:0];
				CFG_SUM_LIMIT: sum_limit_q <= cfg_data[SUM_W-1:0];
				default: ;
			endcase
		end
	end

	// Control state: position, first-row flag, stage valids, sums and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q          <= '0;
			first_row_q    <= 1'b1;
			valid_s1       <= 1'b0;
			rsum_q         <= '0;
			hit_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (pixel.grid_end) begin
					col_q       <= '0;
					first_row_q <= 1'b1;
				end else if (row_end) begin
					col_q       <= '0;
					first_row_q <= 1'b0;
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsum_q         <= (last_s1 || row_end_s1) ? '0 : rsum_sum;
				hit_q          <= last_s1 ? '0 : hit_next;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1     <= pixel.cell_value;
			last_s1     <= pixel.grid_end;
			row_end_s1  <= row_end;
			first_s1    <= first_row_q;
			col_s1      <= col_q;
			byp_s1      <= advance && (col_s1 == col_q);
			byp_data_s1 <= area;
		end
		if (advance) begin
			result_q.area_sum     <= area;
			result_q.within_limit <= hit;
			result_q.hits_so_far  <= hit_next;
			result_q.final_cell   <= last_s1;
		end
	end

endmodule

>>> hw/rtl/iitc_ram.sv
// ----------------------------------------------------------------------------
// iitc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module iitc_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/iitc_chk.sv
// ----------------------------------------------------------------------------
// iitc_chk
// Port-level checker for the integral image threshold count unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iitc_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            pixel_valid,
	input logic                            pixel_stall,
	input iitc_pkg::pixel_t                pixel,
	input logic                            result_valid,
	input logic                            result_stall,
	input iitc_pkg::result_t               result,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [iitc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [iitc_pkg::CFG_DATA_W-1:0] cfg_data
);

	import iitc_pkg::*;

	// A held result keeps its value until the transfer completes.
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, (result_valid && $stable(result)))

	// The input only stalls when a result is waiting behind a stalled output.
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, pixel_stall, (result_valid && result_stall))

	// Every accepted pixel is followed by a valid result in the result register.
	`ASSERT_IMPLIES(a_latency, clk, arst_n, pixel_valid && !pixel_stall, ##2 (result_valid))

	// A counted pixel always leaves a nonzero running count.
	`ASSERT_IMPLIES(a_hit_count, clk, arst_n, result_valid && result.within_limit, (result.hits_so_far != '0))

endmodule

bind integral_image_threshold_count_unit iitc_chk u_chk (.*);
